// ===== sv/sist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sist_pkg;

	localparam int unsigned ID_W     = 31;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned MCOUNT_W = 7;

	// valid identifiers are 1 .. ID_LIMIT-1
	localparam logic [ID_W-1:0] ID_LIMIT = 31'd1234567890;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_LOOKUP = 2'd2
	} req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_INVALID = 3'd1,
		STAT_PRESENT = 3'd2,
		STAT_ABSENT  = 3'd3,
		STAT_FULL    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DECIDE,
		S_UP_RD,
		S_UP_WR,
		S_DN_RD,
		S_DN_WR,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic in_range;
	} cmp_res_t;

endpackage

`default_nettype wire

// ===== sv/sorted_id_set_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// sorted identifier set: keeps up to CAPACITY identifiers in ascending order
// in a single-port-write, single-port-read memory, one compare unit shared
// by the scan and decide steps of a small sequencer.
// s_* channel: one request word, tuser = request kind, tdata = identifier.
// m_* channel: one result word per request, tdata = status and member count.
// a request is taken only while the sequencer is idle. it first walks the
// table from slot 0, reading and comparing one slot at a time, until it finds the
// first entry not below the identifier; an add then moves the upper entries
// up one slot and a remove moves them down, a read and a write per moved entry.
// the sequencer passes through idle once per request, so a new request is
// taken only once the result of the previous one has been loaded.
// the result sits in an output register; if the receiver stalls, the
// sequencer waits in its last state and takes no new request meanwhile.
// reset empties the set at once (count cleared); table contents are not
// cleared since only slots below the count are ever read.
module sorted_id_set_table_unit #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [30:0] ident
	input  wire logic [1:0]  s_tuser,  // [1:0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata   // [2:0] status, [9:3] member_count
);
	import sist_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	logic [CW-1:0]       count_q, p_q, i_q;
	logic [1:0]          kind_q;
	logic [ID_W-1:0]     id_q;
	logic                held_q;
	logic [STATUS_W-1:0] status_q;
	logic                m_tvalid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [MCOUNT_W-1:0] out_count_q;

	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	logic [ID_W-1:0] mem_wdata, mem_rdata;
	cmp_res_t        cmp;

	logic          accept, out_free, scan_end, is_full, up_done, dn_done;
	logic [CW-1:0] i_plus, i_minus;

	sist_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sist_cmp u_cmp (
		.entry (mem_rdata),
		.ident (id_q),
		.res   (cmp)
	);

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign scan_end = p_q >= count_q;
	assign is_full  = count_q == CW'(CAPACITY);
	assign i_plus   = i_q + CW'(1);
	assign i_minus  = i_q - CW'(1);
	assign up_done  = i_q == p_q;
	assign dn_done  = i_plus >= count_q;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_count_q, out_status_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				state_d = scan_end ? S_DECIDE : S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				state_d = cmp.lt ? S_SCAN_RD : S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_FINISH;
				unique case (kind_q)
					REQ_ADD: begin
						if (cmp.in_range && !held_q && !is_full) state_d = S_UP_RD;
					end
					REQ_REMOVE: begin
						if (cmp.in_range && held_q) state_d = S_DN_RD;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_UP_RD: begin
				state_d = up_done ? S_FINISH : S_UP_WR;
			end
			S_UP_WR: state_d = S_UP_RD;
			S_DN_RD: begin
				state_d = dn_done ? S_FINISH : S_DN_WR;
			end
			S_DN_WR: state_d = S_DN_RD;
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = p_q[AW-1:0];
		unique case (state_q)
			S_SCAN_RD: begin
				mem_re = !scan_end;
			end
			S_UP_RD: begin
				if (up_done) begin
					mem_we    = 1'b1;
					mem_waddr = p_q[AW-1:0];
					mem_wdata = id_q;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = i_minus[AW-1:0];
				end
			end
			S_UP_WR: mem_we = 1'b1;
			S_DN_RD: begin
				mem_re    = !dn_done;
				mem_raddr = i_plus[AW-1:0];
			end
			S_DN_WR: mem_we = 1'b1;
			default: begin
				mem_we = 1'b0;
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_UP_RD && up_done) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_DN_RD && dn_done) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == S_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request payload, scan position and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			id_q   <= s_tdata[ID_W-1:0];
			p_q    <= '0;
		end
		if (state_q == S_SCAN_RD && scan_end) begin
			held_q <= 1'b0;
		end
		if (state_q == S_SCAN_CMP) begin
			if (cmp.lt) begin
				p_q <= p_q + CW'(1);
			end else begin
				held_q <= cmp.eq;
			end
		end
		if (state_q == S_DECIDE) begin
			i_q <= (kind_q == REQ_ADD) ? count_q : p_q;
			unique case (kind_q)
				REQ_ADD: begin
					priority if (!cmp.in_range) status_q <= STAT_INVALID;
					else if (held_q)            status_q <= STAT_PRESENT;
					else if (is_full)           status_q <= STAT_FULL;
					else                        status_q <= STAT_OK;
				end
				REQ_REMOVE: begin
					priority if (!cmp.in_range) status_q <= STAT_INVALID;
					else if (!held_q)           status_q <= STAT_ABSENT;
					else                        status_q <= STAT_OK;
				end
				REQ_LOOKUP: status_q <= held_q ? STAT_OK : STAT_ABSENT;
				default:    status_q <= STAT_INVALID;
			endcase
		end
		if (state_q == S_UP_WR) begin
			i_q <= i_minus;
		end
		if (state_q == S_DN_WR) begin
			i_q <= i_plus;
		end
		if (state_q == S_FINISH && out_free) begin
			out_status_q <= status_q;
			out_count_q  <= MCOUNT_W'(count_q);
		end
	end

endmodule

`default_nettype wire

// ===== sv/sist_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sist_cmp (
	input  wire logic [sist_pkg::ID_W-1:0] entry,
	input  wire logic [sist_pkg::ID_W-1:0] ident,
	output sist_pkg::cmp_res_t             res
);
	import sist_pkg::*;

	always_comb begin
		res.lt       = entry < ident;
		res.eq       = entry == ident;
		res.in_range = (ident != '0) && (ident < ID_LIMIT);
	end

endmodule

`default_nettype wire

// ===== sv/sist_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sist_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [sist_pkg::ID_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [AW-1:0]             raddr,
	output logic      [sist_pkg::ID_W-1:0] rdata
);
	import sist_pkg::*;

	logic [ID_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import sist_pkg::*;

	localparam int unsigned CAPACITY   = 64;
	localparam int unsigned POOL_SIZE  = 96;
	localparam int unsigned CYCLE_CAP  = 500000;
	localparam int unsigned DRAIN_WAIT = 2 * CAPACITY + 20;
	localparam logic [1:0]  REQ_SPARE  = 2'd3;
	localparam logic [30:0] ID_TOP     = 31'h7fffffff;

	typedef struct {
		logic [1:0]  kind;
		logic [30:0] id;
	} request_t;

	typedef struct {
		status_t     st;
		logic [6:0]  cnt;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [30:0] ident
	logic [1:0]  s_tuser;   // [1:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [2:0] status, [9:3] member_count

	request_t    pending_reqs[$];
	request_t    next_req;
	outcome_t    expected_outcomes[$];
	outcome_t    want;
	logic [30:0] held_ids[$];
	logic [30:0] id_pool[POOL_SIZE];

	int unsigned reqs_taken;
	int unsigned words_seen;
	int unsigned error_cnt;
	int unsigned cycle_cnt;
	int unsigned hold_left;
	bit          hold_done;

	sorted_id_set_table_unit #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sorted set update; returns the status and the count after the request
	function automatic outcome_t apply_request(logic [1:0] kind, logic [30:0] id);
		outcome_t r;
		int       p;
		bit       hit;
		bit       valid_id;
		p = 0;
		while (p < held_ids.size() && held_ids[p] < id)
			p++;
		hit = (p < held_ids.size()) && (held_ids[p] == id);
		valid_id = (id != 31'd0) && (id < ID_LIMIT);
		case (kind)
			REQ_ADD: begin
				if (!valid_id)
					r.st = STAT_INVALID;
				else if (hit)
					r.st = STAT_PRESENT;
				else if (held_ids.size() >= CAPACITY)
					r.st = STAT_FULL;
				else begin
					held_ids.insert(p, id);
					r.st = STAT_OK;
				end
			end
			REQ_REMOVE: begin
				if (!valid_id)
					r.st = STAT_INVALID;
				else if (!hit)
					r.st = STAT_ABSENT;
				else begin
					held_ids.delete(p);
					r.st = STAT_OK;
				end
			end
			REQ_LOOKUP: begin
				// out-of-range ids are never held, so no range check here
				r.st = hit ? STAT_OK : STAT_ABSENT;
			end
			default: begin
				r.st = STAT_INVALID;
			end
		endcase
		r.cnt = 7'(held_ids.size());
		return r;
	endfunction

	function automatic logic [30:0] pick_id();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return id_pool[$urandom_range(POOL_SIZE - 1)];
		else if (roll < 80)
			return 31'($urandom_range(32'(ID_LIMIT) - 1, 1));
		else if (roll < 90)
			return 31'($urandom);
		case ($urandom_range(4))
			0:       return 31'd0;
			1:       return 31'd1;
			2:       return ID_LIMIT - 31'd1;
			3:       return ID_LIMIT;
			default: return ID_TOP;
		endcase
	endfunction

	task automatic queue_req(logic [1:0] kind, logic [30:0] id);
		request_t r;
		r.kind = kind;
		r.id = id;
		pending_reqs.push_back(r);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			reqs_taken <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_outcomes.push_back(apply_request(s_tuser, s_tdata[30:0]));
				reqs_taken <= reqs_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				// no idling while the quiet window is open
				if (pending_reqs.size() != 0 &&
				    ((reqs_taken >= 200 && reqs_taken < 280) || $urandom_range(99) >= 11)) begin
					next_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, next_req.id};
					s_tuser <= next_req.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			words_seen <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				words_seen <= words_seen + 1;
				if (expected_outcomes.size() == 0) begin
					if (error_cnt < 10)
						$display("unexpected result word: status %0d count %0d",
						         m_tdata[2:0], m_tdata[9:3]);
					error_cnt++;
				end else begin
					want = expected_outcomes.pop_front();
					if (m_tdata[2:0] !== want.st || m_tdata[9:3] !== want.cnt) begin
						if (error_cnt < 10)
							$display("word %0d: expected status %0d count %0d, got status %0d count %0d",
							         words_seen, want.st, want.cnt, m_tdata[2:0], m_tdata[9:3]);
						error_cnt++;
					end
				end
			end
			// one long hold-off so the block backs up into its input
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!hold_done && words_seen >= 120) begin
				hold_left <= 400;
				hold_done <= 1'b1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (words_seen >= 200 && words_seen < 280) ||
				            ($urandom_range(99) >= 11);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_CAP) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		error_cnt = 0;
		cycle_cnt = 0;
		arst_n = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = 31'($urandom_range(32'(ID_LIMIT) - 1, 1));
		id_pool[0] = 31'd1;
		id_pool[1] = ID_LIMIT - 31'd1;

		// directed: empty set, range edges, ordered inserts, spare selector
		queue_req(REQ_LOOKUP, 31'd1);
		queue_req(REQ_REMOVE, 31'd5);
		queue_req(REQ_ADD, 31'd0);
		queue_req(REQ_ADD, ID_LIMIT);
		queue_req(REQ_ADD, ID_TOP);
		queue_req(REQ_ADD, ID_LIMIT - 31'd1);
		queue_req(REQ_ADD, 31'd1);
		queue_req(REQ_ADD, 31'd1000);
		queue_req(REQ_ADD, 31'd500);
		queue_req(REQ_ADD, 31'd1000);
		queue_req(REQ_LOOKUP, 31'd500);
		queue_req(REQ_LOOKUP, 31'd0);
		queue_req(REQ_LOOKUP, ID_TOP);
		queue_req(REQ_LOOKUP, ID_LIMIT);
		queue_req(REQ_REMOVE, 31'd0);
		queue_req(REQ_REMOVE, ID_LIMIT);
		queue_req(REQ_REMOVE, 31'd777);
		queue_req(REQ_SPARE, 31'd1000);
		queue_req(REQ_LOOKUP, 31'd1000);
		queue_req(REQ_REMOVE, 31'd500);
		queue_req(REQ_REMOVE, 31'd1);
		queue_req(REQ_REMOVE, ID_LIMIT - 31'd1);
		queue_req(REQ_REMOVE, 31'd1000);

		// fill past capacity so adds get refused as full
		for (int i = 0; i < 72; i++)
			queue_req(REQ_ADD, id_pool[i]);
		queue_req(REQ_ADD, ID_LIMIT - 31'd2);
		queue_req(REQ_ADD, id_pool[3]);

		// mixed traffic, biased toward adds so the set hovers near full
		for (int i = 0; i < 250; i++) begin
			case ($urandom_range(99)) inside
				[0:39]:  queue_req(REQ_ADD, pick_id());
				[40:69]: queue_req(REQ_REMOVE, pick_id());
				[70:96]: queue_req(REQ_LOOKUP, pick_id());
				default: queue_req(REQ_SPARE, 31'($urandom));
			endcase
		end

		for (int i = 0; i < POOL_SIZE; i++)
			queue_req(REQ_REMOVE, id_pool[i]);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_cnt == 0 && expected_outcomes.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
